// ----- src/mtc_pkg.sv -----
`default_nettype none

package mtc_pkg;

  // Tick counter width; stamps and all stored times wrap at 2^TIME_BITS.
  localparam int TIME_BITS = 16;

  localparam int CFG_BITS = 8;
  localparam int CMD_BITS = 2;
  localparam int SYM_BITS = 3;
  localparam int CFG_IDX_BITS = 1;

  // Width of the calibration cross-products (largest factor is 301 < 2^9).
  localparam int CAL_BITS = TIME_BITS + 9;
  // Signed width of the timing windows: up to 7*(dot+tol) plus a sign bit.
  localparam int WIN_BITS = TIME_BITS + 5;

  localparam int CAL_FIRST_MUL = 100;
  localparam int CAL_SHORT_MUL = 35;
  localparam int CAL_LONG_MUL = 301;

  localparam logic [CFG_BITS-1:0] TOL_RESET = CFG_BITS'(10);
  localparam logic [CFG_BITS-1:0] FOFS_RESET = CFG_BITS'(5);

  localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_FALL_OFFSET = CFG_IDX_BITS'(1);

  localparam logic [CMD_BITS-1:0] CMD_RISE = CMD_BITS'(0);
  localparam logic [CMD_BITS-1:0] CMD_FALL = CMD_BITS'(1);
  localparam logic [CMD_BITS-1:0] CMD_BUTTON = CMD_BITS'(2);

  localparam logic [SYM_BITS-1:0] SYM_NONE = SYM_BITS'(0);
  localparam logic [SYM_BITS-1:0] SYM_DOT = SYM_BITS'(1);
  localparam logic [SYM_BITS-1:0] SYM_DASH = SYM_BITS'(2);
  localparam logic [SYM_BITS-1:0] SYM_CHAR = SYM_BITS'(3);
  localparam logic [SYM_BITS-1:0] SYM_WORD = SYM_BITS'(4);
  localparam logic [SYM_BITS-1:0] SYM_BADGAP = SYM_BITS'(5);
  localparam logic [SYM_BITS-1:0] SYM_BADPULSE = SYM_BITS'(6);
  localparam logic [SYM_BITS-1:0] SYM_CAL = SYM_BITS'(7);

  typedef enum logic [5:0] {
    M_CAL_RISE = 6'b000001,
    M_CAL_FALL = 6'b000010,
    M_EOC_RISE = 6'b000100,
    M_EOC_FALL = 6'b001000,
    M_DEC_FALL = 6'b010000,
    M_DEC_RISE = 6'b100000
  } mode_t;

  typedef struct packed {
    mode_t                mode;
    logic [TIME_BITS-1:0] rise_time;
    logic [TIME_BITS-1:0] fall_time;
    logic [TIME_BITS-1:0] dot_length;
    logic [TIME_BITS-1:0] first_width;
  } mtc_state_t;

endpackage

`default_nettype wire

// ----- src/morse_timing_classifier.sv -----
`default_nettype none

// Morse timing classifier: feed it timestamped line rise, line fall and
// button events; it learns the dot length from a pair of pulses (reported
// as symbol 7), then reports each gap after it as no symbol (one dot),
// character end, word end or bad gap, and once a character or word end is
// seen, each pulse as dot, dash or bad pulse; the windows are one, three
// and seven times dot+-tolerance. Every accepted item gives exactly one
// result item, with symbol 0 when nothing is to be reported. It takes one
// item per clock cycle while the input is not stalled; an accepted item is
// held in the input register, which feeds the decision logic, which loads
// the result register and updates the timing state. The input stalls only
// while its register holds an item and a result is stalled. Write
// tolerance and fall_offset only while no items are in flight.
module morse_timing_classifier (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mtc_pkg::CMD_BITS-1:0]         in_cmd,
  input  logic [mtc_pkg::TIME_BITS-1:0]        in_stamp,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mtc_pkg::SYM_BITS-1:0]         out_symbol,
  output logic [mtc_pkg::TIME_BITS-1:0]        out_dot_ticks,
  input  logic                                 cfg_we,
  input  logic [mtc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [mtc_pkg::CFG_BITS-1:0]         cfg_wdata
);
  import mtc_pkg::*;

  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  logic [CMD_BITS-1:0]  s1_cmd_r;
  logic [TIME_BITS-1:0] s1_stamp_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [SYM_BITS-1:0]  out_symbol_r;
  logic [TIME_BITS-1:0] out_dot_r;
  logic [CFG_BITS-1:0]  tol_r;
  logic [CFG_BITS-1:0]  fofs_r;
  mtc_state_t           state_r;
  mtc_state_t           state_nxt;
  logic [SYM_BITS-1:0]  sym_nxt;
  logic                 out_free;
  logic                 in_acc;
  logic                 proc;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc = in_valid && !in_stall;
  assign proc = s1_valid_r && out_free;

  assign s1_valid_nxt = out_free ? in_valid : (s1_valid_r || in_valid);
  assign out_valid_nxt = out_free ? s1_valid_r : out_valid_r;

  mtc_decide u_decide (
    .st          (state_r),
    .cmd         (s1_cmd_r),
    .stamp       (s1_stamp_r),
    .tolerance   (tol_r),
    .fall_offset (fofs_r),
    .st_nxt      (state_nxt),
    .symbol      (sym_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      tol_r <= TOL_RESET;
      fofs_r <= FOFS_RESET;
      state_r.mode <= M_CAL_RISE;
      state_r.rise_time <= '0;
      state_r.fall_time <= '0;
      state_r.dot_length <= '0;
      state_r.first_width <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TOLERANCE:   tol_r <= cfg_wdata;
          REG_FALL_OFFSET: fofs_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (proc) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r <= in_cmd;
      s1_stamp_r <= in_stamp;
    end
    if (proc) begin
      out_symbol_r <= sym_nxt;
      out_dot_r <= state_nxt.dot_length;
    end
  end

  assign out_valid = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_dot_ticks = out_dot_r;

  // the dot length changes only together with a calibration result
  a_dot_only_on_cal: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && state_r.dot_length != $past(state_r.dot_length)) |->
      (out_valid_r && out_symbol_r == SYM_CAL))
    else $error("dot length changed without calibration result");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  a_pulse_in_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && (sym_nxt == SYM_DOT || sym_nxt == SYM_DASH ||
              sym_nxt == SYM_BADPULSE)) |=> (state_r.mode == M_DEC_RISE))
    else $error("pulse classified outside decoding");

  a_button_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && s1_cmd_r == CMD_BUTTON) |=> (out_symbol_r == SYM_NONE))
    else $error("button press produced a symbol");

endmodule

`default_nettype wire

// ----- src/mtc_decide.sv -----
`default_nettype none

module mtc_decide (
  input  mtc_pkg::mtc_state_t                st,
  input  logic [mtc_pkg::CMD_BITS-1:0]       cmd,
  input  logic [mtc_pkg::TIME_BITS-1:0]      stamp,
  input  logic [mtc_pkg::CFG_BITS-1:0]       tolerance,
  input  logic [mtc_pkg::CFG_BITS-1:0]       fall_offset,
  output mtc_pkg::mtc_state_t                st_nxt,
  output logic [mtc_pkg::SYM_BITS-1:0]       symbol
);
  import mtc_pkg::*;

  logic [TIME_BITS-1:0] fall_adj;
  logic [TIME_BITS-1:0] width;
  logic [TIME_BITS-1:0] gap;
  logic [CAL_BITS-1:0]  first_x;
  logic [CAL_BITS-1:0]  short_x;
  logic [CAL_BITS-1:0]  long_x;
  logic                 keep_first;
  logic                 keep_second;

  logic signed [WIN_BITS-1:0] dot_s;
  logic signed [WIN_BITS-1:0] tol_s;
  logic signed [WIN_BITS-1:0] lo1;
  logic signed [WIN_BITS-1:0] hi1;
  logic signed [WIN_BITS-1:0] lo3;
  logic signed [WIN_BITS-1:0] hi3;
  logic signed [WIN_BITS-1:0] lo7;
  logic signed [WIN_BITS-1:0] hi7;
  logic signed [WIN_BITS-1:0] gap_s;
  logic signed [WIN_BITS-1:0] width_s;
  logic [SYM_BITS-1:0]        gap_sym;
  logic [SYM_BITS-1:0]        pulse_sym;

  assign fall_adj = stamp - TIME_BITS'(fall_offset);
  // Pulse width ends at the adjusted fall; gap ends at the new rise.
  assign width = fall_adj - st.rise_time;
  assign gap = stamp - st.fall_time;

  assign first_x = CAL_BITS'(st.first_width) * CAL_BITS'(CAL_FIRST_MUL);
  assign short_x = CAL_BITS'(width) * CAL_BITS'(CAL_SHORT_MUL);
  assign long_x = CAL_BITS'(width) * CAL_BITS'(CAL_LONG_MUL);
  assign keep_first = first_x < short_x;
  assign keep_second = first_x >= long_x;

  assign dot_s = $signed(WIN_BITS'(st.dot_length));
  assign tol_s = $signed(WIN_BITS'(tolerance));
  assign lo1 = dot_s - tol_s;
  assign hi1 = dot_s + tol_s;
  assign lo3 = lo1 + (lo1 <<< 1);
  assign hi3 = hi1 + (hi1 <<< 1);
  assign lo7 = (lo1 <<< 3) - lo1;
  assign hi7 = (hi1 <<< 3) - hi1;
  assign gap_s = $signed(WIN_BITS'(gap));
  assign width_s = $signed(WIN_BITS'(width));

  always_comb begin
    priority if (gap_s > lo1 && gap_s < hi1) begin
      gap_sym = SYM_NONE;
    end else if (gap_s >= lo3 && gap_s <= hi3) begin
      gap_sym = SYM_CHAR;
    end else if (gap_s >= lo7 && gap_s <= hi7) begin
      gap_sym = SYM_WORD;
    end else begin
      gap_sym = SYM_BADGAP;
    end
  end

  always_comb begin
    priority if (width_s >= lo1 && width_s <= hi1) begin
      pulse_sym = SYM_DOT;
    end else if (width_s >= lo3 && width_s <= hi3) begin
      pulse_sym = SYM_DASH;
    end else begin
      pulse_sym = SYM_BADPULSE;
    end
  end

  always_comb begin
    st_nxt = st;
    symbol = SYM_NONE;
    unique case (cmd)
      CMD_BUTTON: begin
        // after calibration, restart it and keep the learned dot
        if (st.mode == M_EOC_RISE || st.mode == M_EOC_FALL ||
            st.mode == M_DEC_RISE || st.mode == M_DEC_FALL) begin
          st_nxt.mode = M_CAL_RISE;
          st_nxt.first_width = '0;
        end
      end
      CMD_RISE: begin
        unique case (st.mode)
          M_CAL_RISE: begin
            st_nxt.rise_time = stamp;
            st_nxt.mode = M_CAL_FALL;
          end
          M_EOC_RISE: begin
            st_nxt.rise_time = stamp;
            symbol = gap_sym;
            st_nxt.mode = (gap_sym == SYM_CHAR || gap_sym == SYM_WORD) ?
                          M_DEC_FALL : M_EOC_FALL;
          end
          M_DEC_RISE: begin
            st_nxt.rise_time = stamp;
            symbol = gap_sym;
            st_nxt.mode = M_DEC_FALL;
          end
          default: ;
        endcase
      end
      CMD_FALL: begin
        unique case (st.mode)
          M_CAL_FALL: begin
            st_nxt.fall_time = fall_adj;
            priority if (st.first_width == '0) begin
              st_nxt.first_width = width;
              st_nxt.mode = M_CAL_RISE;
            end else if (keep_first) begin
              st_nxt.dot_length = st.first_width;
              symbol = SYM_CAL;
              st_nxt.mode = M_EOC_RISE;
            end else if (keep_second) begin
              st_nxt.dot_length = width;
              symbol = SYM_CAL;
              st_nxt.mode = M_EOC_RISE;
            end else begin
              // slide the pair on
              st_nxt.first_width = width;
              st_nxt.mode = M_CAL_RISE;
            end
          end
          M_EOC_FALL: begin
            st_nxt.fall_time = fall_adj;
            st_nxt.mode = M_EOC_RISE;
          end
          M_DEC_FALL: begin
            st_nxt.fall_time = fall_adj;
            symbol = pulse_sym;
            st_nxt.mode = M_DEC_RISE;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import mtc_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_UNUSED = CMD_BITS'(3);
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [CMD_BITS-1:0]  cmd;
    logic [TIME_BITS-1:0] stamp;
    int                   idle_after;
  } line_event_t;

  typedef struct {
    logic [SYM_BITS-1:0]  symbol;
    logic [TIME_BITS-1:0] dot_ticks;
  } symbol_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_BITS-1:0]  in_cmd = CMD_RISE;
  logic [TIME_BITS-1:0] in_stamp = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SYM_BITS-1:0]  out_symbol;
  logic [TIME_BITS-1:0] out_dot_ticks;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_TOLERANCE;
  logic [CFG_BITS-1:0]  cfg_wdata = '0;

  morse_timing_classifier dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_stamp     (in_stamp),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_symbol   (out_symbol),
    .out_dot_ticks(out_dot_ticks),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  line_event_t line_events[$];
  symbol_t     due_symbols[$];

  int cycle_cnt = 0;
  int fail_cnt = 0;
  int items_queued = 0;
  int results_seen = 0;
  int counted_items = 0;

  // Shadow of the decoder state and its registers
  mode_t                st_mode = M_CAL_RISE;
  logic [TIME_BITS-1:0] st_rise = '0;
  logic [TIME_BITS-1:0] st_fall = '0;
  logic [TIME_BITS-1:0] st_dot = '0;
  logic [TIME_BITS-1:0] st_first = '0;
  logic [CFG_BITS-1:0]  cur_tol = TOL_RESET;
  logic [CFG_BITS-1:0]  cur_fofs = FOFS_RESET;

  // Time cursor of the stimulus: the offset-free time of the last fall
  logic [TIME_BITS-1:0] now = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("tb NOT OK");
    $finish;
  end

  // Stretches with no idling, otherwise a random idle drawn per item
  function automatic int idle_draw(int n);
    return ((n / 48) % 4 == 1) ? 0 : int'($urandom_range(0, 9));
  endfunction

  function automatic bit in_band(int v, int k);
    int d, t;
    d = int'(st_dot);
    t = int'(cur_tol);
    return v >= k * (d - t) && v <= k * (d + t);
  endfunction

  task automatic classify_event(input logic [CMD_BITS-1:0] cmd,
                                input logic [TIME_BITS-1:0] stamp);
    logic [SYM_BITS-1:0]  sym;
    logic [TIME_BITS-1:0] w;
    int                   v, d, t;
    int unsigned          lhs;
    sym = SYM_NONE;
    d = int'(st_dot);
    t = int'(cur_tol);
    case (cmd)
      CMD_BUTTON: begin
        if (st_mode inside {M_EOC_RISE, M_EOC_FALL, M_DEC_RISE, M_DEC_FALL}) begin
          st_mode = M_CAL_RISE;
          st_first = '0;
        end
      end
      CMD_RISE: begin
        if (st_mode == M_CAL_RISE) begin
          st_rise = stamp;
          st_mode = M_CAL_FALL;
        end else if (st_mode == M_EOC_RISE || st_mode == M_DEC_RISE) begin
          st_rise = stamp;
          w = st_rise - st_fall;
          v = int'(w);
          if (v > d - t && v < d + t) sym = SYM_NONE;
          else if (in_band(v, 3)) sym = SYM_CHAR;
          else if (in_band(v, 7)) sym = SYM_WORD;
          else sym = SYM_BADGAP;
          if (st_mode == M_DEC_RISE || sym == SYM_CHAR || sym == SYM_WORD) begin
            st_mode = M_DEC_FALL;
          end else begin
            st_mode = M_EOC_FALL;
          end
        end
      end
      CMD_FALL: begin
        if (st_mode == M_CAL_FALL) begin
          st_fall = stamp - TIME_BITS'(cur_fofs);
          w = st_fall - st_rise;
          lhs = 100 * int'(st_first);
          if (st_first == '0) begin
            st_first = w;
          end else if (lhs < 35 * int'(w)) begin
            st_dot = st_first;
            sym = SYM_CAL;
          end else if (lhs >= 301 * int'(w)) begin
            st_dot = w;
            sym = SYM_CAL;
          end else begin
            st_first = w;
          end
          st_mode = (sym == SYM_CAL) ? M_EOC_RISE : M_CAL_RISE;
        end else if (st_mode == M_EOC_FALL) begin
          st_fall = stamp - TIME_BITS'(cur_fofs);
          st_mode = M_EOC_RISE;
        end else if (st_mode == M_DEC_FALL) begin
          st_fall = stamp - TIME_BITS'(cur_fofs);
          w = st_fall - st_rise;
          v = int'(w);
          if (in_band(v, 1)) sym = SYM_DOT;
          else if (in_band(v, 3)) sym = SYM_DASH;
          else sym = SYM_BADPULSE;
          st_mode = M_DEC_RISE;
        end
      end
      default: ;
    endcase
    due_symbols.push_back('{sym, st_dot});
  endtask

  // Driver: hold a stalled item, idle after each item, then take the next
  always begin : drive_items
    bit          took;
    int          idle_left;
    line_event_t ev;
    logic        v_next;
    @(posedge clk);
    took = rst_n && in_valid && !in_stall;
    if (took) classify_event(in_cmd, in_stamp);
    @(negedge clk);
    v_next = 1'b0;
    if (in_valid && !took) begin
      v_next = 1'b1;
    end else if (idle_left > 0) begin
      idle_left--;
    end else if (line_events.size() > 0) begin
      ev = line_events.pop_front();
      in_cmd <= ev.cmd;
      in_stamp <= ev.stamp;
      idle_left = ev.idle_after;
      v_next = 1'b1;
    end
    in_valid <= v_next;
  end

  always begin : watch_results
    bit      took;
    int      stall_left;
    symbol_t exp_sym;
    @(posedge clk);
    took = rst_n && out_valid && !out_stall;
    if (took) begin
      if (due_symbols.size() == 0) begin
        $error("unexpected result: symbol %0d, dot_ticks %0d", out_symbol, out_dot_ticks);
        fail_cnt++;
      end else begin
        exp_sym = due_symbols.pop_front();
        if (out_symbol !== exp_sym.symbol) begin
          $error("symbol: expected %0d, got %0d", exp_sym.symbol, out_symbol);
          fail_cnt++;
        end
        if (out_dot_ticks !== exp_sym.dot_ticks) begin
          $error("dot_ticks: expected %0d, got %0d", exp_sym.dot_ticks, out_dot_ticks);
          fail_cnt++;
        end
      end
      results_seen++;
    end
    @(negedge clk);
    if (took) stall_left = idle_draw(results_seen);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic queue_event(input logic [CMD_BITS-1:0] cmd,
                             input logic [TIME_BITS-1:0] stamp);
    line_events.push_back('{cmd, stamp, idle_draw(items_queued)});
    items_queued++;
  endtask

  // Rise after the given gap, fall after the given width plus the fall offset
  task automatic send_pulse(input int gap, input int width);
    now = now + TIME_BITS'(gap);
    queue_event(CMD_RISE, now);
    now = now + TIME_BITS'(width);
    queue_event(CMD_FALL, now + TIME_BITS'(cur_fofs));
    counted_items += 2;
  endtask

  // k dots long, spread over the window, sometimes on its edges or past them
  function automatic int wobble(int base, int k);
    int span, v;
    span = k * int'(cur_tol);
    case ($urandom_range(0, 9))
      0: v = base - span;
      1: v = base + span;
      2: v = base + span + 1 + int'($urandom_range(0, base / 2 + 4));
      3: v = base - span - 1 - int'($urandom_range(0, base / 2 + 4));
      default: v = base - span + int'($urandom_range(0, 2 * span));
    endcase
    return (v < 0) ? 0 : v;
  endfunction

  function automatic int mark_len(int d);
    int k;
    case ($urandom_range(0, 6))
      0: k = 5;
      1, 2, 3: k = 1;
      default: k = 3;
    endcase
    return wobble(k * d, k);
  endfunction

  task automatic send_message();
    int d, n, k;
    d = ($urandom_range(0, 15) == 0) ? int'($urandom_range(400, 9000))
                                     : int'($urandom_range(4, 300));
    case ($urandom_range(0, 3))
      0, 1: begin
        send_pulse($urandom_range(1, 8 * d), d);
        send_pulse($urandom_range(1, 8 * d), 3 * d + int'($urandom_range(0, d)));
      end
      2: begin
        send_pulse($urandom_range(1, 8 * d), 4 * d + int'($urandom_range(0, d)));
        send_pulse($urandom_range(1, 8 * d), d);
      end
      default: begin
        // slide once before the pair settles
        send_pulse($urandom_range(1, 8 * d), 2 * d);
        send_pulse($urandom_range(1, 8 * d), d);
        send_pulse($urandom_range(1, 8 * d), 3 * d);
      end
    endcase
    k = ($urandom_range(0, 1) == 0) ? 3 : 7;
    send_pulse(wobble(k * d, k), mark_len(d));
    n = $urandom_range(2, 20);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0: k = 5;
        1, 2, 3: k = 1;
        4, 5: k = 3;
        default: k = 7;
      endcase
      send_pulse(wobble(k * d, k), mark_len(d));
    end
    if ($urandom_range(0, 9) < 7) queue_event(CMD_BUTTON, TIME_BITS'($urandom()));
  endtask

  task automatic random_phase(input int count);
    int start;
    start = counted_items;
    while (counted_items - start < count) begin
      send_message();
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          queue_event(CMD_BITS'($urandom_range(0, 3)), TIME_BITS'($urandom()));
        end
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (!(line_events.size() == 0 && !in_valid && due_symbols.size() == 0));
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TOLERANCE) cur_tol = val;
    else cur_fofs = val;
  endtask

  task automatic directed_items();
    queue_event(CMD_BUTTON, 16'h0000);
    queue_event(CMD_UNUSED, 16'hFFFF);
    queue_event(CMD_FALL, 16'h5A5A);
    now = 16'hFFE0;
    // slide, then a zero second width calibrates to a zero dot
    send_pulse(7, 20);
    send_pulse(50, 30);
    send_pulse(60, 0);
    queue_event(CMD_BUTTON, 16'h1234);
    // short then long: dot 40
    send_pulse(70, 40);
    send_pulse(80, 140);
    // bad gap while waiting: the next fall is not classified
    send_pulse(60, 10);
    // one-dot gap while waiting: no symbol
    send_pulse(40, 25);
    send_pulse(120, 30);
    send_pulse(50, 90);
    send_pulse(350, 200);
    queue_event(CMD_BUTTON, 16'h8000);
    // long then short right on the ratio boundary
    send_pulse(5, 301);
    send_pulse(9, 100);
  endtask

  initial begin : run
    logic [CFG_BITS-1:0] tol_set[5];
    logic [CFG_BITS-1:0] fofs_set[5];
    tol_set = '{8'd0, 8'd255, CFG_BITS'($urandom()), 8'd255, CFG_BITS'($urandom_range(0, 40))};
    fofs_set = '{8'd0, 8'd255, CFG_BITS'($urandom()), 8'd0, CFG_BITS'($urandom())};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    directed_items();
    wait_idle();
    for (int i = 0; i < 5; i++) begin
      write_reg(REG_TOLERANCE, tol_set[i]);
      write_reg(REG_FALL_OFFSET, fofs_set[i]);
      random_phase(140);
      wait_idle();
    end
    repeat (20) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
